>>> src/biquad_iir_filter_unit_defines.svh
// Assertion macros used by the biquad filter checker.
`ifndef BIQUAD_IIR_FILTER_UNIT_DEFINES_SVH
`define BIQUAD_IIR_FILTER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BQF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bqf: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define BQF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bqf: next-cycle check failed");

`endif

>>> src/bqf_pkg.sv
// Shared constants and types of the biquad IIR filter unit.
`timescale 1ns / 1ps
package bqf_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int STATE_WIDTH_DEF    = 24;

  localparam int COEF_WIDTH  = 18;
  localparam int COEF_COUNT  = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_B0 = CFG_IDX_W'(0),
    IDX_B1 = CFG_IDX_W'(1),
    IDX_B2 = CFG_IDX_W'(2),
    IDX_A1 = CFG_IDX_W'(3),
    IDX_A2 = CFG_IDX_W'(4)
  } coef_idx_e;

endpackage

>>> src/bqf_if.sv
// Handshake interfaces for the sample, result and coefficient channels.
`timescale 1ns / 1ps
interface bqf_in_if import bqf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqf_out_if import bqf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           guard_hit;

  modport source (output valid, output sample_out, output guard_hit, input ready);
  modport sink   (input valid, input sample_out, input guard_hit, output ready);
endinterface

interface bqf_cfg_if import bqf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [COEF_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/bqf_front.sv
// Front end: accepts sample beats into a short queue ahead of the filter datapath.
`timescale 1ns / 1ps
module bqf_front import bqf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bqf_in_if.sink                         in_i,
  output logic                           q_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] q_sample_o,
  input  logic                           q_ready_i
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic signed [SAMPLE_WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign in_i.ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_sample_o = mem_q[rd_ptr_q];

  assign push = in_i.valid && in_i.ready;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i.sample_in;
    end
  end

endmodule

>>> src/bqf_back.sv
// Back end: coefficient registers, delay line and the multi-cycle filter datapath.
`timescale 1ns / 1ps
module bqf_back import bqf_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int STATE_WIDTH    = STATE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  logic signed [SAMPLE_WIDTH-1:0] q_sample_i,
  output logic                           q_ready_o,
  bqf_cfg_if.sink                        cfg_i,
  bqf_out_if.source                      out_o
);

  localparam int PROD_W = COEF_WIDTH + STATE_WIDTH;
  localparam int XS_W   = SAMPLE_WIDTH + COEF_FRAC_BITS;
  localparam int SF_W   = STATE_WIDTH + COEF_FRAC_BITS;
  localparam int FB_M1  = (XS_W > PROD_W) ? XS_W : PROD_W;
  localparam int FB_W   = ((FB_M1 > SF_W) ? FB_M1 : SF_W) + 2;
  localparam int W0F_W  = FB_W - COEF_FRAC_BITS;
  localparam int FF_W   = ((PROD_W + 2) > (XS_W + 1)) ? (PROD_W + 2) : (XS_W + 1);
  localparam int YF_W   = FF_W - COEF_FRAC_BITS;

  localparam logic signed [FB_W-1:0] FB_HALF = FB_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [FF_W-1:0] FF_HALF = FF_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [COEF_WIDTH-1:0] B0_RESET = COEF_WIDTH'(1 << COEF_FRAC_BITS);
  localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_W0,
    ST_MUL,
    ST_SUM
  } state_e;

  state_e state_q, state_d;

  logic signed [COEF_WIDTH-1:0]   b0_q, b0_d, b1_q, b1_d, b2_q, b2_d;
  logic signed [COEF_WIDTH-1:0]   a1_q, a1_d, a2_q, a2_d;
  logic signed [STATE_WIDTH-1:0]  delay_one_q, delay_one_d, delay_two_q, delay_two_d;
  logic signed [SAMPLE_WIDTH-1:0] x_q, x_d;
  logic signed [FB_W-1:0]         fb_acc_q, fb_acc_d;
  logic signed [STATE_WIDTH-1:0]  w0_q, w0_d;
  logic                           guard_q, guard_d;
  logic signed [FF_W-1:0]         ff_part_q, ff_part_d;
  logic signed [PROD_W-1:0]       p0_q, p0_d;
  logic                           out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_q, sample_out_d;
  logic                           guard_out_q, guard_out_d;

  logic signed [XS_W-1:0]         xs;
  logic signed [PROD_W-1:0]       pa1, pa2, pb1, pb2;
  logic signed [FB_W-1:0]         fb_rnd;
  logic signed [W0F_W-1:0]        w0_full;
  logic signed [STATE_WIDTH-1:0]  w0_trunc, w0_sel;
  logic                           w0_fit;
  logic signed [FF_W-1:0]         ff_sum;
  logic signed [YF_W-1:0]         y_full;
  logic signed [SAMPLE_WIDTH-1:0] y_trunc, y_sat;
  logic                           out_free;

  assign q_ready_o   = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = sample_out_q;
  assign out_o.guard_hit  = guard_out_q;
  assign out_free         = !out_valid_q || out_o.ready;

  // feedback sum
  assign xs  = XS_W'(q_sample_i) <<< COEF_FRAC_BITS;
  assign pa1 = a1_q * delay_one_q;
  assign pa2 = a2_q * delay_two_q;

  // w0 rounding and overflow guard
  assign fb_rnd   = fb_acc_q + FB_HALF;
  assign w0_full  = $signed(fb_rnd[FB_W-1:COEF_FRAC_BITS]);
  assign w0_trunc = $signed(w0_full[STATE_WIDTH-1:0]);
  assign w0_fit   = (w0_full == W0F_W'(w0_trunc));
  assign w0_sel   = w0_fit ? w0_trunc : STATE_WIDTH'(x_q);

  // feed-forward terms on the old delay line
  assign pb1 = b1_q * delay_one_q;
  assign pb2 = b2_q * delay_two_q;

  // output rounding and saturation
  assign ff_sum  = FF_W'(p0_q) + ff_part_q + FF_HALF;
  assign y_full  = $signed(ff_sum[FF_W-1:COEF_FRAC_BITS]);
  assign y_trunc = $signed(y_full[SAMPLE_WIDTH-1:0]);
  assign y_sat   = (y_full == YF_W'(y_trunc)) ? y_trunc
                 : (y_full[YF_W-1] ? Y_MIN : Y_MAX);

  always_comb begin
    state_d      = state_q;
    b0_d         = b0_q;
    b1_d         = b1_q;
    b2_d         = b2_q;
    a1_d         = a1_q;
    a2_d         = a2_q;
    delay_one_d  = delay_one_q;
    delay_two_d  = delay_two_q;
    x_d          = x_q;
    fb_acc_d     = fb_acc_q;
    w0_d         = w0_q;
    guard_d      = guard_q;
    ff_part_d    = ff_part_q;
    p0_d         = p0_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    sample_out_d = sample_out_q;
    guard_out_d  = guard_out_q;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          x_d      = q_sample_i;
          fb_acc_d = FB_W'(xs) - FB_W'(pa1) - FB_W'(pa2);
          state_d  = ST_W0;
        end
      end
      ST_W0: begin
        w0_d        = w0_sel;
        guard_d     = !w0_fit;
        ff_part_d   = FF_W'(pb1) + FF_W'(pb2);
        delay_two_d = delay_one_q;
        delay_one_d = w0_sel;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        p0_d    = b0_q * w0_q;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          sample_out_d = y_sat;
          guard_out_d  = guard_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // the user must write coefficients only while the datapath is idle; the block itself does not enforce it
    if (cfg_i.valid) begin
      case (coef_idx_e'(cfg_i.index))
        IDX_B0:  b0_d = $signed(cfg_i.data);
        IDX_B1:  b1_d = $signed(cfg_i.data);
        IDX_B2:  b2_d = $signed(cfg_i.data);
        IDX_A1:  a1_d = $signed(cfg_i.data);
        IDX_A2:  a2_d = $signed(cfg_i.data);
        default: ;
      endcase
      if (cfg_i.index < CFG_IDX_W'(COEF_COUNT)) begin
        delay_one_d = '0;
        delay_two_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      b0_q         <= B0_RESET;
      b1_q         <= '0;
      b2_q         <= '0;
      a1_q         <= '0;
      a2_q         <= '0;
      delay_one_q  <= '0;
      delay_two_q  <= '0;
      x_q          <= '0;
      fb_acc_q     <= '0;
      w0_q         <= '0;
      guard_q      <= 1'b0;
      ff_part_q    <= '0;
      p0_q         <= '0;
      out_valid_q  <= 1'b0;
      sample_out_q <= '0;
      guard_out_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      b0_q         <= b0_d;
      b1_q         <= b1_d;
      b2_q         <= b2_d;
      a1_q         <= a1_d;
      a2_q         <= a2_d;
      delay_one_q  <= delay_one_d;
      delay_two_q  <= delay_two_d;
      x_q          <= x_d;
      fb_acc_q     <= fb_acc_d;
      w0_q         <= w0_d;
      guard_q      <= guard_d;
      ff_part_q    <= ff_part_d;
      p0_q         <= p0_d;
      out_valid_q  <= out_valid_d;
      sample_out_q <= sample_out_d;
      guard_out_q  <= guard_out_d;
    end
  end

endmodule

>>> src/biquad_iir_filter_unit.sv
// Top level of the biquad IIR filter unit (direct form II, fixed point).
// Channels: in_i carries one signed sample per beat, out_o one filtered sample
// plus a guard flag per beat, cfg_i writes coefficient registers b0, b1, b2, a1, a2
// at indexes 0..4; a write to a valid index also clears the delay line, other
// indexes are dropped. cfg_i.ready is always high; write only while idle.
// The datapath runs one sample at a time through the sequence of feedback
// multiply-add, w0 round and guard with b1/b2 products, b0 multiply, and final
// sum with saturation, and takes no new sample until the last one is done.
// A two-beat queue ahead of the datapath keeps in_i ready while a result waits.
// Reset: b0 = 1.0, other coefficients 0, delay line zero, queue and output empty.
// Receiver stall: the output register holds its beat, the datapath waits with
// the next result, the queue fills and then in_i.ready drops.
`timescale 1ns / 1ps
module biquad_iir_filter_unit import bqf_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int STATE_WIDTH    = STATE_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bqf_cfg_if.sink   cfg_i,
  bqf_in_if.sink    in_i,
  bqf_out_if.source out_o
);

  logic                           q_valid;
  logic                           q_ready;
  logic signed [SAMPLE_WIDTH-1:0] q_sample;

  bqf_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_valid_o  (q_valid),
    .q_sample_o (q_sample),
    .q_ready_i  (q_ready)
  );

  bqf_back #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .STATE_WIDTH    (STATE_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_sample_i (q_sample),
    .q_ready_o  (q_ready),
    .cfg_i      (cfg_i),
    .out_o      (out_o)
  );

endmodule

>>> src/bqf_checker.sv
// Port-level checker for the biquad IIR filter unit, bound to the top level.
`timescale 1ns / 1ps
`include "biquad_iir_filter_unit_defines.svh"
module bqf_checker import bqf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0] sample_out_i,
  input logic                           guard_hit_i
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 3);

  logic [CNT_W-1:0] pending_q, pending_d;
  logic             in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_beat && !out_beat) begin
      pending_d = pending_q + CNT_W'(1);
    end else if (out_beat && !in_beat) begin
      pending_d = pending_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `BQF_ASSERT_IMPL(a_pending_bound, clk_i, rst_ni, 1'b1, pending_q <= CNT_W'(QUEUE_DEPTH + 2))
  `BQF_ASSERT_IMPL(a_out_has_item, clk_i, rst_ni, out_valid_i, pending_q != '0)
  `BQF_ASSERT_IMPL(a_stall_only_full, clk_i, rst_ni, in_valid_i && !in_ready_i, pending_q >= CNT_W'(QUEUE_DEPTH))
  `BQF_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `BQF_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(sample_out_i) && $stable(guard_hit_i))

endmodule

bind biquad_iir_filter_unit bqf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bqf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .sample_out_i (out_o.sample_out),
  .guard_hit_i  (out_o.guard_hit)
);

>>> tb/biquad_iir_filter_unit_tb.sv
// Self-checking testbench for the biquad IIR filter unit: predicts every output beat.
`timescale 1ns / 1ps
module biquad_iir_filter_unit_tb;
  import bqf_pkg::*;

  localparam int SW  = SAMPLE_WIDTH_DEF;
  localparam int FB  = COEF_FRAC_BITS_DEF;
  localparam int STW = STATE_WIDTH_DEF;

  localparam longint STATE_MAX  = (longint'(1) <<< (STW - 1)) - 1;
  localparam longint STATE_MIN  = -STATE_MAX - 1;
  localparam longint OUT_MAX    = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint OUT_MIN    = -OUT_MAX - 1;
  localparam longint ROUND_HALF = longint'(1) <<< (FB - 1);

  localparam logic [COEF_WIDTH-1:0] COEF_POS_MAX = {1'b0, {(COEF_WIDTH - 1){1'b1}}};
  localparam logic [COEF_WIDTH-1:0] COEF_NEG_MAX = {1'b1, {(COEF_WIDTH - 1){1'b0}}};
  localparam logic [COEF_WIDTH-1:0] COEF_ZERO    = '0;
  localparam logic [CFG_IDX_W-1:0]  IDX_SPARE_LO = CFG_IDX_W'(COEF_COUNT);
  localparam logic [CFG_IDX_W-1:0]  IDX_SPARE_HI = '1;

  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int STABLE_A2_SPAN  = 58982;
  localparam int CYCLE_LIMIT     = 400000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic signed [SW-1:0] sample_out;
    logic                 guard_hit;
  } filt_result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [COEF_WIDTH-1:0] data;
  } coef_write_t;

  logic clk_i;
  logic rst_ni;

  bqf_in_if  #(.SAMPLE_WIDTH(SW)) in_if ();
  bqf_out_if #(.SAMPLE_WIDTH(SW)) out_if ();
  bqf_cfg_if                      cfg_if ();

  biquad_iir_filter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic signed [SW-1:0] sample_backlog[$];
  coef_write_t          coef_backlog[$];
  filt_result_t         expected_out[$];
  filt_result_t         want;
  coef_write_t          next_write;

  longint coef_val[COEF_COUNT];
  longint delay_one_q;
  longint delay_two_q;

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int cycle_count;

  always #5 clk_i = ~clk_i;

  function automatic filt_result_t biquad_step(input logic signed [SW-1:0] x);
    filt_result_t r;
    longint       xs;
    longint       acc;
    longint       w0;
    longint       y;
    xs  = x;
    acc = (xs <<< FB) - coef_val[IDX_A1] * delay_one_q - coef_val[IDX_A2] * delay_two_q;
    w0  = (acc + ROUND_HALF) >>> FB;
    r.guard_hit = 1'b0;
    if (w0 > STATE_MAX || w0 < STATE_MIN) begin
      w0 = xs;
      r.guard_hit = 1'b1;
    end
    acc = coef_val[IDX_B0] * w0 + coef_val[IDX_B1] * delay_one_q
        + coef_val[IDX_B2] * delay_two_q;
    y = (acc + ROUND_HALF) >>> FB;
    if (y > OUT_MAX) y = OUT_MAX;
    if (y < OUT_MIN) y = OUT_MIN;
    r.sample_out = SW'(y);
    delay_two_q = delay_one_q;
    delay_one_q = w0;
    return r;
  endfunction

  function automatic void apply_coef_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [COEF_WIDTH-1:0] data);
    if (idx < IDX_SPARE_LO) begin
      coef_val[idx] = longint'($signed(data));
      delay_one_q = 0;
      delay_two_q = 0;
    end
  endfunction

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct  = 76;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 76;
      end
      default: begin
        send_idle_pct  = 20;
        recv_stall_pct = 20;
      end
    endcase
  endtask

  task automatic wait_coefs_written();
    while (coef_backlog.size() != 0 || cfg_if.valid) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (sample_backlog.size() != 0 || in_if.valid || expected_out.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic run_phase(input int p);
    logic [COEF_WIDTH-1:0] c[COEF_COUNT];
    logic signed [SW-1:0]  s;
    int                    a2v;
    int                    span;
    int                    r;
    set_idling(idle_mode_e'(p % 4));
    for (int i = 0; i < COEF_COUNT; i++) begin
      if (p == 0) c[i] = COEF_POS_MAX;
      else if (p == 1) c[i] = COEF_NEG_MAX;
      else if (p % 2 == 1) c[i] = COEF_WIDTH'($urandom);
      else c[i] = COEF_WIDTH'(int'($urandom_range(0, 2 * (1 << FB))) - (1 << FB));
    end
    // stable pole pair: |a2| < 1, |a1| < 1 + a2
    if (p >= 2 && p % 2 == 0) begin
      a2v  = int'($urandom_range(0, 2 * STABLE_A2_SPAN)) - STABLE_A2_SPAN;
      span = (1 << FB) + a2v - 1;
      c[IDX_A2] = COEF_WIDTH'(a2v);
      c[IDX_A1] = COEF_WIDTH'(int'($urandom_range(0, 2 * span)) - span);
    end
    for (int i = 0; i < COEF_COUNT; i++) coef_backlog.push_back('{CFG_IDX_W'(i), c[i]});
    if (p % 2 == 1)
      coef_backlog.push_back('{CFG_IDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)),
                               COEF_WIDTH'($urandom)});
    wait_coefs_written();
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      r = $urandom_range(99);
      if (r < 10) s = $urandom_range(1) ? SW'(OUT_MAX) : SW'(OUT_MIN);
      else if (r < 20) s = SW'(int'($urandom_range(0, 511)) - 256);
      else s = SW'($urandom);
      sample_backlog.push_back(s);
    end
    wait_drained();
  endtask

  // config channel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_if.valid <= 1'b0;
      cfg_if.index <= '0;
      cfg_if.data  <= '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) apply_coef_write(cfg_if.index, cfg_if.data);
      if (!cfg_if.valid || cfg_if.ready) begin
        if (coef_backlog.size() != 0) begin
          next_write = coef_backlog.pop_front();
          cfg_if.valid <= 1'b1;
          cfg_if.index <= next_write.index;
          cfg_if.data  <= next_write.data;
        end else begin
          cfg_if.valid <= 1'b0;
        end
      end
    end
  end

  // sample driver; prediction made on each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.sample_in <= '0;
    end else begin
      if (in_if.valid && in_if.ready) expected_out.push_back(biquad_step(in_if.sample_in));
      if (!in_if.valid || in_if.ready) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid     <= 1'b1;
          in_if.sample_in <= sample_backlog.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_out.size() == 0) begin
          $error("result beat with no expected result: sample_out %0d guard_hit %0b",
                 out_if.sample_out, out_if.guard_hit);
          fail_count++;
        end else begin
          want = expected_out.pop_front();
          if (out_if.sample_out !== want.sample_out) begin
            $error("sample_out mismatch: expected %0d, actual %0d",
                   want.sample_out, out_if.sample_out);
            fail_count++;
          end
          if (out_if.guard_hit !== want.guard_hit) begin
            $error("guard_hit mismatch: expected %0b, actual %0b",
                   want.guard_hit, out_if.guard_hit);
            fail_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    out_if.ready    = 1'b0;
    fail_count      = 0;
    cycle_count     = 0;
    coef_val[IDX_B0] = longint'(1) <<< FB;
    coef_val[IDX_B1] = 0;
    coef_val[IDX_B2] = 0;
    coef_val[IDX_A1] = 0;
    coef_val[IDX_A2] = 0;
    delay_one_q = 0;
    delay_two_q = 0;
    set_idling(IDLE_NONE);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset coefficients: pass-through
    sample_backlog.push_back(SW'(OUT_MIN));
    sample_backlog.push_back(SW'(OUT_MAX));
    sample_backlog.push_back(SW'(0));
    sample_backlog.push_back(SW'(-1));
    sample_backlog.push_back(SW'(1));
    sample_backlog.push_back(SW'(16'h5555));
    sample_backlog.push_back(SW'(16'hAAAA));
    wait_drained();

    // a1 = -2.0 makes w0 double each beat until the guard trips; b at extremes saturate
    coef_backlog.push_back('{IDX_B0, COEF_POS_MAX});
    coef_backlog.push_back('{IDX_B1, COEF_NEG_MAX});
    coef_backlog.push_back('{IDX_B2, COEF_POS_MAX});
    coef_backlog.push_back('{IDX_A1, COEF_NEG_MAX});
    coef_backlog.push_back('{IDX_A2, COEF_ZERO});
    coef_backlog.push_back('{IDX_SPARE_LO, COEF_WIDTH'($urandom)});
    wait_coefs_written();
    repeat (10) sample_backlog.push_back(SW'(OUT_MAX));
    wait_drained();

    // spare index: write dropped, delay line kept
    coef_backlog.push_back('{IDX_SPARE_HI, COEF_WIDTH'($urandom)});
    wait_coefs_written();
    sample_backlog.push_back(SW'(OUT_MIN));
    sample_backlog.push_back(SW'(OUT_MIN));
    sample_backlog.push_back(SW'(0));
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) run_phase(p);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/bqf_pkg.sv
src/bqf_if.sv
src/bqf_front.sv
src/bqf_back.sv
src/biquad_iir_filter_unit.sv
src/bqf_checker.sv
tb/biquad_iir_filter_unit_tb.sv
